### hw/rtl/tam_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the argmax-along-axis unit.
// No dependencies; the other files that use it refer to this package by scoped names.
package tam_pkg;

	localparam int MAX_INNER  = 1024;
	localparam int SLOT_W     = $clog2(MAX_INNER);
	localparam int VAL_W      = 16;
	localparam int IDX_W      = 16;
	localparam int POS_W      = 32;
	localparam int OUTER_W    = 16;
	localparam int AXIS_W     = 16;
	localparam int INNER_W    = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_OUTER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_AXIS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_INNER = 2'd2;

	localparam logic [INNER_W-1:0] INNER_LIMIT = INNER_W'(MAX_INNER);

	// Per-item control travelling from the position counters to the update stage
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [AXIS_W-1:0] axis;
		logic              first;
		logic              emit;
		logic              fin;
		logic [POS_W-1:0]  pos;
	} tam_tag_t;

	// One entry of the running-maximum memory
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        index;
	} tam_best_t;

	localparam int BEST_W = $bits(tam_best_t);

endpackage

### hw/rtl/tam_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the argmax unit: samples, results, config.
// Depends on tam_pkg for field widths.
interface tam_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [tam_pkg::VAL_W-1:0]    sample_value;
	modport source (output valid, output sample_value, input ready);
	modport sink (input valid, input sample_value, output ready);
endinterface

interface tam_out_if;
	logic                       valid;
	logic                       ready;
	logic [tam_pkg::IDX_W-1:0]  argmax_index;
	logic [tam_pkg::POS_W-1:0]  output_position;
	logic                       final_result;
	modport source (output valid, output argmax_index, output output_position,
		output final_result, input ready);
	modport sink (input valid, input argmax_index, input output_position,
		input final_result, output ready);
endinterface

interface tam_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tam_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [tam_pkg::CFG_DATA_W-1:0] reg_data;
	modport source (output valid, output reg_index, output reg_data, input ready);
	modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

### hw/rtl/tam_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one registered read port.
// Read returns the old contents when reading and writing the same address.
module tam_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/tam_seq.sv
`timescale 1ns / 1ps
// Shape registers and position counters (outer, axis, inner, result count).
// Depends on tam_pkg; produces the tag of the item at the input.
module tam_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tam_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tam_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              step,
	output tam_pkg::tam_tag_t                 tag
);

	logic [tam_pkg::OUTER_W-1:0] cnt_outer_q;
	logic [tam_pkg::AXIS_W-1:0]  cnt_axis_q;
	logic [tam_pkg::INNER_W-1:0] cnt_inner_q;
	logic [tam_pkg::OUTER_W-1:0] pos_outer_q;
	logic [tam_pkg::AXIS_W-1:0]  pos_axis_q;
	logic [tam_pkg::SLOT_W-1:0]  pos_inner_q;
	logic [tam_pkg::POS_W-1:0]   out_cnt_q;

	logic [tam_pkg::OUTER_W-1:0] n_outer;
	logic [tam_pkg::AXIS_W-1:0]  n_axis;
	logic [tam_pkg::INNER_W-1:0] n_inner_raw;
	logic [tam_pkg::INNER_W-1:0] n_inner;
	logic                        last_outer;
	logic                        last_axis;
	logic                        last_inner;

	// Zero counts act as one; the inner count saturates at the memory depth
	always_comb begin
		n_outer     = (cnt_outer_q == '0) ? tam_pkg::OUTER_W'(1) : cnt_outer_q;
		n_axis      = (cnt_axis_q == '0) ? tam_pkg::AXIS_W'(1) : cnt_axis_q;
		n_inner_raw = (cnt_inner_q == '0) ? tam_pkg::INNER_W'(1) : cnt_inner_q;
		n_inner     = (n_inner_raw > tam_pkg::INNER_LIMIT) ? tam_pkg::INNER_LIMIT : n_inner_raw;
		last_outer  = ({1'b0, pos_outer_q} + (tam_pkg::OUTER_W+1)'(1)) >= {1'b0, n_outer};
		last_axis   = ({1'b0, pos_axis_q} + (tam_pkg::AXIS_W+1)'(1)) >= {1'b0, n_axis};
		last_inner  = ({1'b0, tam_pkg::INNER_W'(pos_inner_q)} + (tam_pkg::INNER_W+1)'(1))
			>= {1'b0, n_inner};
	end

	always_comb begin
		tag.slot  = pos_inner_q;
		tag.axis  = pos_axis_q;
		tag.first = (pos_axis_q == '0);
		tag.emit  = last_axis;
		tag.fin   = last_axis && last_inner && last_outer;
		tag.pos   = out_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_outer_q <= tam_pkg::OUTER_W'(1);
			cnt_axis_q  <= tam_pkg::AXIS_W'(1);
			cnt_inner_q <= tam_pkg::INNER_W'(1);
			pos_outer_q <= '0;
			pos_axis_q  <= '0;
			pos_inner_q <= '0;
			out_cnt_q   <= '0;
		end else if (cfg_we && (cfg_index == tam_pkg::REG_COUNT_OUTER ||
				cfg_index == tam_pkg::REG_COUNT_AXIS ||
				cfg_index == tam_pkg::REG_COUNT_INNER)) begin
			// Any shape write restarts the tensor
			case (cfg_index)
				tam_pkg::REG_COUNT_OUTER: cnt_outer_q <= cfg_data[tam_pkg::OUTER_W-1:0];
				tam_pkg::REG_COUNT_AXIS:  cnt_axis_q  <= cfg_data[tam_pkg::AXIS_W-1:0];
				tam_pkg::REG_COUNT_INNER: cnt_inner_q <= cfg_data[tam_pkg::INNER_W-1:0];
				default: ;
			endcase
			pos_outer_q <= '0;
			pos_axis_q  <= '0;
			pos_inner_q <= '0;
			out_cnt_q   <= '0;
		end else if (step) begin
			// The last result of a tensor wraps the result count back to zero
			if (last_axis && last_inner && last_outer) begin
				out_cnt_q <= '0;
			end else if (last_axis) begin
				out_cnt_q <= out_cnt_q + tam_pkg::POS_W'(1);
			end
			if (!last_inner) begin
				pos_inner_q <= pos_inner_q + tam_pkg::SLOT_W'(1);
			end else begin
				pos_inner_q <= '0;
				if (!last_axis) begin
					pos_axis_q <= pos_axis_q + tam_pkg::AXIS_W'(1);
				end else begin
					pos_axis_q <= '0;
					if (!last_outer) begin
						pos_outer_q <= pos_outer_q + tam_pkg::OUTER_W'(1);
					end else begin
						pos_outer_q <= '0;
					end
				end
			end
		end
	end

endmodule

### hw/rtl/tensor_argmax_along_axis_unit.sv
`timescale 1ns / 1ps
// Streaming argmax along one tensor axis: one element item per cycle while the output is not stalled.
// A result item is loaded into the output register when its last axis element leaves stage 1.
// The running-maximum RAM has a single read/write port pair, read at acceptance
// and written when the item leaves stage 1, with a forwarding register between.
// Reset (arst_n low, asynchronous): shape counts return to 1, positions and the
// result count to 0, pipeline and output emptied; RAM contents are left as they are.
module tensor_argmax_along_axis_unit (
	input  logic      clk,
	input  logic      arst_n,
	tam_in_if.sink    samples,
	tam_out_if.source results,
	tam_cfg_if.sink   cfg
);

	tam_pkg::tam_tag_t  tag;
	tam_pkg::tam_tag_t  tag_s1;
	logic               s1_valid_q;
	logic signed [tam_pkg::VAL_W-1:0] value_s1;

	logic [tam_pkg::BEST_W-1:0] rd_data;
	tam_pkg::tam_best_t held;
	tam_pkg::tam_best_t new_best;
	logic               take_new;

	logic                       fwd_valid_q;
	logic [tam_pkg::SLOT_W-1:0] fwd_slot_q;
	tam_pkg::tam_best_t         fwd_best_q;

	logic                       out_valid_q;
	logic [tam_pkg::IDX_W-1:0]  out_index_q;
	logic [tam_pkg::POS_W-1:0]  out_pos_q;
	logic                       out_fin_q;

	logic advance;
	logic take;

	// Config is always accepted; the user must write it only while the unit is idle, the block does not enforce this
	assign cfg.ready = 1'b1;

	// Stall only when stage 1 holds a result and the output register is still full
	assign advance       = !(s1_valid_q && tag_s1.emit && out_valid_q && !results.ready);
	assign take          = samples.valid && advance;
	assign samples.ready = advance;

	tam_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_index (cfg.reg_index),
		.cfg_data  (cfg.reg_data),
		.step      (take),
		.tag       (tag)
	);

	// Running best value and index per inner position
	tam_ram #(
		.DEPTH (tam_pkg::MAX_INNER),
		.WIDTH (tam_pkg::BEST_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (advance),
		.rd_addr (tag.slot),
		.rd_data (rd_data),
		.wr_en   (advance && s1_valid_q),
		.wr_addr (tag_s1.slot),
		.wr_data (new_best)
	);

	// Stage 1: item waits here while its RAM read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tag_s1   <= tag;
			value_s1 <= samples.sample_value;
		end
	end

	// The write of the item just ahead lands on the same edge as our read:
	// pick it up from the forwarding register instead of the stale RAM word
	always_comb begin
		if (fwd_valid_q && fwd_slot_q == tag_s1.slot) begin
			held = fwd_best_q;
		end else begin
			held = tam_pkg::tam_best_t'(rd_data);
		end
		// Strictly greater replaces, so the first maximum along the axis wins
		take_new = tag_s1.first || ($signed(value_s1) > $signed(held.value));
		if (take_new) begin
			new_best.value = value_s1;
			new_best.index = tag_s1.axis;
		end else begin
			new_best = held;
		end
	end

	// Track the write made on the last advancing edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (advance) begin
			fwd_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			fwd_slot_q <= tag_s1.slot;
			fwd_best_q <= new_best;
		end
	end

	// Output register: load on the last axis element, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && s1_valid_q && tag_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q && tag_s1.emit) begin
			out_index_q <= new_best.index;
			out_pos_q   <= tag_s1.pos;
			out_fin_q   <= tag_s1.fin;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.argmax_index    = out_index_q;
	assign results.output_position = out_pos_q;
	assign results.final_result    = out_fin_q;

	// The last result of a tensor always closes a slice
	a_fin_emits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && tag_s1.fin |-> tag_s1.emit)
		else $error("final flag on an item that closes no slice");

	// Only the first element of a slice sits at axis position zero
	a_first_axis: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !tag_s1.first |-> tag_s1.axis != '0)
		else $error("non-first element at axis position zero");

	// Forwarded data always comes from an item that was in stage 1
	a_fwd_source: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_valid_q |-> $past(s1_valid_q))
		else $error("forwarding register valid without a preceding write");

	// A stalled stage 1 never loses its pending result
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> s1_valid_q && tag_s1.emit && $stable(tag_s1))
		else $error("stage 1 changed while stalled");

endmodule
